FILE: hdl/bitmap_block_allocator_macros.svh
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bba_pkg.sv
// Types and constants shared by the bitmap block allocator modules.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int CFG_W   = 9;
  localparam int REQ_W   = 16;
  localparam int START_W = 8;
  localparam int BYTES_W = 15;
  localparam int MARK_W  = 2;

  localparam logic [BYTES_W-1:0] BYTES_SAT = 15'h7fff;

  typedef enum logic [MARK_W-1:0] {
    MK_FREE   = 2'd0,
    MK_USED   = 2'd1,
    MK_BORDER = 2'd2
  } bba_mark_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ZERO    = 2'd2,
    ST_IGNORED = 2'd3
  } bba_status_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic               vld;
    bba_status_t        status;
    logic [START_W-1:0] start_block;
  } bba_done_t;

  typedef struct packed {
    bba_status_t        status;
    logic [START_W-1:0] start_block;
    logic [BYTES_W-1:0] used_bytes;
    logic [BYTES_W-1:0] free_bytes;
  } bba_result_t;

endpackage

FILE: hdl/bba_mark_ram.sv
// Block mark store: one write port, one registered read port.
`timescale 1ns / 1ps
module bba_mark_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 2
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/bba_report.sv
// Result formatting: byte totals from the block counts, registered strobe.
`timescale 1ns / 1ps
module bba_report #(
  parameter int BLOCK_BYTES = 64,
  parameter int CW          = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bba_pkg::bba_done_t   done,
  input  logic [CW-1:0]        used_count,
  input  logic [CW-1:0]        n_eff,
  output bba_pkg::bba_result_t result,
  output logic                 result_vld
);
  import bba_pkg::*;

  logic [31:0]        used_prod;
  logic [31:0]        free_prod;
  logic [CW-1:0]      spare_blks;
  bba_result_t        result_r, result_nxt;
  logic               vld_r;

  assign spare_blks = (n_eff > used_count) ? (n_eff - used_count) : '0;
  assign used_prod  = 32'(used_count) * 32'(BLOCK_BYTES);
  assign free_prod  = 32'(spare_blks) * 32'(BLOCK_BYTES);

  always_comb begin
    result_nxt.status      = done.status;
    result_nxt.start_block = done.start_block;
    result_nxt.used_bytes  = (used_prod > 32'(BYTES_SAT)) ? BYTES_SAT : used_prod[BYTES_W-1:0];
    result_nxt.free_bytes  = (free_prod > 32'(BYTES_SAT)) ? BYTES_SAT : free_prod[BYTES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= done.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (done.vld) begin
      result_r <= result_nxt;
    end
  end

  assign result     = result_r;
  assign result_vld = vld_r;

endmodule

FILE: hdl/bba_seq.sv
// Request sequencer: clearing pass, first-fit scan, run fill and release walk.
`timescale 1ns / 1ps
module bba_seq #(
  parameter int MAX_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 64,
  parameter int AW          = 8,
  parameter int CW          = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bba_pkg::REQ_W-1:0]   release_offset,
  input  logic [CW-1:0]               n_eff,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [bba_pkg::MARK_W-1:0]  rd_data,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [bba_pkg::MARK_W-1:0]  wr_data,
  output logic [CW-1:0]               used_count,
  output bba_pkg::bba_done_t          done
);
  import bba_pkg::*;

  localparam int RBW = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_FILL   = 8'b0000_1000,
    S_LOCATE = 8'b0001_0000,
    S_CHECK  = 8'b0010_0000,
    S_WALK   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } seq_state_t;

  seq_state_t          state_r, state_nxt;
  logic [CW-1:0]       addr_r, addr_nxt;       // scan / fill / locate / walk / clear pointer
  logic [AW-1:0]       eval_addr_r, eval_addr_nxt;
  logic                eval_vld_r, eval_vld_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic [RBW-1:0]      runb_r, runb_nxt;
  logic [AW-1:0]       first_r, first_nxt;
  logic [REQ_W-1:0]    base_r, base_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  bba_status_t         status_r, status_nxt;
  logic [START_W-1:0]  start_r, start_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [REQ_W-1:0]    off_r, off_nxt;

  logic [CW-1:0]       run_inc;
  logic [RBW-1:0]      runb_inc;
  logic [CW-1:0]       first_calc;
  logic [CW-1:0]       used_dec;
  logic [REQ_W:0]      block_end;

  assign run_inc    = run_r + CW'(1);
  assign runb_inc   = runb_r + RBW'(BLOCK_BYTES);
  assign first_calc = CW'(eval_addr_r) + CW'(1) - run_inc;
  assign used_dec   = (used_r != '0) ? (used_r - CW'(1)) : used_r;
  assign block_end  = {1'b0, base_r} + (REQ_W+1)'(BLOCK_BYTES);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    eval_addr_nxt = eval_addr_r;
    eval_vld_nxt  = eval_vld_r;
    run_nxt       = run_r;
    runb_nxt      = runb_r;
    first_nxt     = first_r;
    base_nxt      = base_r;
    used_nxt      = used_r;
    status_nxt    = status_r;
    start_nxt     = start_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    rd_en         = 1'b0;
    rd_addr       = addr_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = addr_r[AW-1:0];
    wr_data       = MK_FREE;

    case (state_r)
      S_CLEAR: begin
        wr_en    = 1'b1;
        addr_nxt = addr_r + CW'(1);
        if (addr_r == CW'(MAX_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt      = request_bytes;
          off_nxt      = release_offset;
          start_nxt    = '0;
          addr_nxt     = '0;
          eval_vld_nxt = 1'b0;
          run_nxt      = '0;
          runb_nxt     = '0;
          base_nxt     = '0;
          if (opcode == OP_RELEASE) begin
            state_nxt = S_LOCATE;
          end else if (request_bytes == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, previous block evaluated alongside
        eval_vld_nxt = 1'b0;
        if (addr_r < n_eff) begin
          rd_en         = 1'b1;
          eval_addr_nxt = addr_r[AW-1:0];
          eval_vld_nxt  = 1'b1;
          addr_nxt      = addr_r + CW'(1);
        end
        if (eval_vld_r) begin
          if (rd_data == MK_FREE) begin
            run_nxt  = run_inc;
            runb_nxt = runb_inc;
            if (32'(runb_inc) >= 32'(req_r)) begin
              first_nxt     = first_calc[AW-1:0];
              start_nxt     = START_W'(first_calc[AW-1:0]);
              addr_nxt      = first_calc;
              eval_addr_nxt = eval_addr_r;
              state_nxt     = S_FILL;
            end
          end else begin
            run_nxt  = '0;
            runb_nxt = '0;
          end
        end else if (!(addr_r < n_eff)) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end
      end

      S_FILL: begin
        wr_en    = 1'b1;
        wr_data  = (addr_r[AW-1:0] == first_r) ? MK_BORDER : MK_USED;
        addr_nxt = addr_r + CW'(1);
        if (addr_r[AW-1:0] == eval_addr_r) begin
          used_nxt   = used_r + run_r;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end

      S_LOCATE: begin
        // step to the block holding the offset
        if (!(addr_r < n_eff)) begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_DONE;
        end else if ({1'b0, off_r} >= block_end) begin
          addr_nxt = addr_r + CW'(1);
          base_nxt = block_end[REQ_W-1:0];
        end else begin
          rd_en         = 1'b1;
          eval_addr_nxt = addr_r[AW-1:0];
          state_nxt     = S_CHECK;
        end
      end

      S_CHECK: begin
        if (rd_data == MK_BORDER) begin
          wr_en        = 1'b1;
          wr_addr      = eval_addr_r;
          used_nxt     = used_dec;
          addr_nxt     = addr_r + CW'(1);
          eval_vld_nxt = 1'b0;
          state_nxt    = S_WALK;
        end else begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_DONE;
        end
      end

      S_WALK: begin
        eval_vld_nxt = 1'b0;
        if (addr_r < n_eff) begin
          rd_en         = 1'b1;
          eval_addr_nxt = addr_r[AW-1:0];
          eval_vld_nxt  = 1'b1;
          addr_nxt      = addr_r + CW'(1);
        end
        if (eval_vld_r) begin
          if (rd_data == MK_USED) begin
            wr_en    = 1'b1;
            wr_addr  = eval_addr_r;
            used_nxt = used_dec;
          end else begin
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end
        end else if (!(addr_r < n_eff)) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      eval_vld_r <= 1'b0;
      used_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      eval_vld_r <= eval_vld_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_addr_r <= eval_addr_nxt;
    run_r       <= run_nxt;
    runb_r      <= runb_nxt;
    first_r     <= first_nxt;
    base_r      <= base_nxt;
    status_r    <= status_nxt;
    start_r     <= start_nxt;
    req_r       <= req_nxt;
    off_r       <= off_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign used_count       = used_r;
  assign done.vld         = (state_r == S_DONE);
  assign done.status      = status_r;
  assign done.start_block = start_r;

endmodule

FILE: hdl/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
`timescale 1ns / 1ps
// Usage
//  - Request channel: drive in_opcode (0 allocate, 1 release), in_request_bytes
//    and in_release_offset with start high; the request is taken at the edge
//    where start is high and busy is low. busy stays high until the result.
//  - Result channel: out_valid is high for exactly one cycle with out_status,
//    out_start_block, out_used_bytes and out_free_bytes. The receiver cannot
//    stall; the result must be taken in that cycle.
//  - Configuration: cfg_wr_en with cfg_wr_data sets the block count; write it
//    only while idle. Counts above MAX_BLOCKS are treated as MAX_BLOCKS.
//  - Processing: marks are read through the mark RAM, one mark read per cycle.
//    A zero-size allocate goes straight to the result. An allocate scans first
//    fit up to the end block of the first run that fits, then writes the run;
//    a release steps to the block holding the offset, checks it, then frees the
//    run. One request at a time: the next one can be taken in the cycle the
//    result shows.
//  - Reset: synchronous, active low. After reset a clearing pass writes every
//    mark free, one block a cycle, with busy high; the block
//    count returns to min(256, MAX_BLOCKS) and the used count to zero.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [bba_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [bba_pkg::REQ_W-1:0]     in_release_offset,
  // result channel
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [bba_pkg::START_W-1:0]   out_start_block,
  output logic [bba_pkg::BYTES_W-1:0]   out_used_bytes,
  output logic [bba_pkg::BYTES_W-1:0]   out_free_bytes,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_wr_data
);
  import bba_pkg::*;

`include "bitmap_block_allocator_macros.svh"

  localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  localparam int NB_RST = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

  // block count register and its clamp to the RAM depth
  logic [CFG_W-1:0]  cfg_num_blocks_r;
  logic [CW-1:0]     n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_blocks_r <= CFG_W'(NB_RST);
    end else if (cfg_wr_en) begin
      cfg_num_blocks_r <= cfg_wr_data;
    end
  end

  assign n_eff = (32'(cfg_num_blocks_r) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                            : CW'(cfg_num_blocks_r);

  // mark RAM ports
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [MARK_W-1:0]  rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [MARK_W-1:0]  wr_data;

  logic [CW-1:0]      used_count;
  bba_done_t          done;
  bba_result_t        result;

  bba_mark_ram #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW),
    .DW    (MARK_W)
  ) u_mark_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // sequencer: owns the mark traffic and the used block count
  bba_seq #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode         (in_opcode),
    .request_bytes  (in_request_bytes),
    .release_offset (in_release_offset),
    .n_eff          (n_eff),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .used_count     (used_count),
    .done           (done)
  );

  // byte totals and the one-cycle result strobe
  bba_report #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CW          (CW)
  ) u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .used_count (used_count),
    .n_eff      (n_eff),
    .result     (result),
    .result_vld (out_valid)
  );

  assign out_status      = result.status;
  assign out_start_block = result.start_block;
  assign out_used_bytes  = result.used_bytes;
  assign out_free_bytes  = result.free_bytes;

  // checks
  `BBA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request taken but not busy")
  `BBA_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while still busy")
  `BBA_ASSERT_NXT(a_result_pulse, clk, rst_n, out_valid, !out_valid, "result held over a cycle")
  `BBA_ASSERT_IMP(a_start_zero, clk, rst_n, out_valid && (out_status != ST_OK) && (out_status != ST_IGNORED), out_start_block == '0, "start block set on failed allocate")

endmodule
